FILE: src/opi_pkg.sv
`default_nettype none
package opi_pkg;

   // item codes
   localparam logic MODE_VELOCITY = 1'b0;
   localparam logic MODE_RESET    = 1'b1;
   localparam logic KIND_UPDATE   = 1'b0;
   localparam logic KIND_RESET    = 1'b1;
   localparam logic INTEG_EULER    = 1'b0;
   localparam logic INTEG_MIDPOINT = 1'b1;

   // arithmetic constants
   localparam logic [31:0] ANG_K     = 32'd2867080570;
   // one million is 64 * 15625; 15625 is divided by a reciprocal scaled by 2^45
   localparam logic [31:0] DIV_ODD   = 32'd15625;
   localparam logic [31:0] DIV_RECIP = 32'd2251799814;
   localparam int          CORDIC_N  = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic        mode;
      logic [31:0] stamp_us;
      logic [31:0] lin_x;
      logic [31:0] lin_y;
      logic [31:0] ang_z;
      logic [31:0] new_x;
      logic [31:0] new_y;
      logic [31:0] new_heading;
   } req_payload_type;

   typedef struct packed {
      logic        reply_kind;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] heading;
      logic [31:0] twist_x;
      logic [31:0] twist_y;
      logic [31:0] twist_omega;
   } rsp_payload_type;

   // status of an iterative unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // arctangent of 2^-i in binary-angle units
   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/opi_mul.sv
`default_nettype none
module opi_mul (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic      [63:0] mul_p
);
   logic [63:0] product_ff;

   // shared unsigned multiplier, product registered
   always_ff @(posedge clock) begin
      product_ff <= mul_a * mul_b;
   end

   assign mul_p = product_ff;
endmodule
`default_nettype wire

FILE: src/opi_div.sv
`default_nettype none
module opi_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [63:0]          dividend,
   output logic      [63:0]          quotient,
   output opi_pkg::unit_status_type  status
);
   import opi_pkg::*;

   logic [31:0] x_ff, x_in;
   logic [35:0] low_ff, low_in;
   logic [18:0] q_ff, q_in;
   logic [63:0] quo_ff, quo_in;
   logic [1:0]  dig_ff, dig_in;
   logic        phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [31:0] rem;

   // division by one million: drop six bits, then divide by 15625 in three
   // 18-bit digits; each digit is a reciprocal multiply for the quotient
   // digit and a multiply-subtract for the remainder
   assign mul_a = phase_ff ? {13'd0, q_ff} : x_ff;
   assign mul_b = phase_ff ? DIV_ODD : DIV_RECIP;
   assign prod  = mul_a * mul_b;
   assign rem   = x_ff - prod[31:0];

   always_comb begin
      x_in     = x_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      quo_in   = quo_ff;
      dig_in   = dig_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      if (start) begin
         x_in     = {10'd0, dividend[63:42]};
         low_in   = dividend[41:6];
         quo_in   = '0;
         dig_in   = '0;
         phase_in = 1'b0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            q_in     = prod[63:45];
            phase_in = 1'b1;
         end else begin
            quo_in   = {quo_ff[45:0], q_ff[17:0]};
            x_in     = {rem[13:0], low_ff[35:18]};
            low_in   = {low_ff[17:0], 18'd0};
            phase_in = 1'b0;
            dig_in   = dig_ff + 2'd1;
            if (dig_ff == 2'd2) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         dig_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         dig_ff   <= dig_in;
      end
      x_ff   <= x_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule
`default_nettype wire

FILE: src/opi_cordic.sv
`default_nettype none
module opi_cordic (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [31:0]          angle,
   output logic signed [33:0]        cos_q30,
   output logic signed [33:0]        sin_q30,
   output opi_pkg::unit_status_type  status
);
   import opi_pkg::*;

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               flip_ff, flip_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [33:0] z0, xs, ys, at;

   assign z0 = $signed({{2{angle[31]}}, angle});
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = $signed({4'b0000, atan_entry(cnt_ff)});

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         // fold into the right half plane
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = z0;
         flip_in = 1'b0;
         if (z0 > 34'sd1073741824) begin
            z_in    = z0 - 34'sd2147483648;
            flip_in = 1'b1;
         end else if (z0 < -34'sd1073741824) begin
            z_in    = z0 + 34'sd2147483648;
            flip_in = 1'b1;
         end
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(CORDIC_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign cos_q30     = flip_ff ? -x_ff : x_ff;
   assign sin_q30     = flip_ff ? -y_ff : y_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule
`default_nettype wire

FILE: src/planar_odometry_integrator_core.sv
`default_nettype none
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_payload (velocity sample or pose reset)
// rsp     | out       | rsp_valid/rsp_stall | rsp_payload (new or old pose, twist used)
// csr     | in        | csr_wr_en           | csr_wr_data (integration mode)
//
// a velocity sample is paced by the 30-step cordic, and both reciprocal divider
// passes run under it; a pose reset goes from idle straight to the result state
// req_stall is high while an item is worked on
// synchronous active-high reset clears pose, held twist, stamp and mode
// a finished result waits in a state of its own when the rsp register is still stalled
module planar_odometry_integrator_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire opi_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output opi_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data
);
   import opi_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL_M  = 4'd1;  // |omega| * dt
   localparam logic [3:0] ST_MUL_KL = 4'd2;  // low word * angle constant
   localparam logic [3:0] ST_MUL_KH = 4'd3;  // high word * angle constant
   localparam logic [3:0] ST_MUL_VX = 4'd4;  // angle step done, |vx| * dt
   localparam logic [3:0] ST_MUL_VY = 4'd5;  // |vy| * dt, start divider and cordic
   localparam logic [3:0] ST_DIV_X  = 4'd6;
   localparam logic [3:0] ST_DIV_Y  = 4'd7;
   localparam logic [3:0] ST_MUL_XC = 4'd8;
   localparam logic [3:0] ST_MUL_YS = 4'd9;
   localparam logic [3:0] ST_MUL_XS = 4'd10;
   localparam logic [3:0] ST_MUL_YC = 4'd11;
   localparam logic [3:0] ST_SUM_Y  = 4'd12;
   localparam logic [3:0] ST_UPDATE = 4'd13;
   localparam logic [3:0] ST_OUT    = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic        integ_ff, integ_in;
   logic [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in, pose_h_ff, pose_h_in;
   logic [31:0] held_x_ff, held_x_in, held_y_ff, held_y_in, held_w_ff, held_w_in;
   logic [31:0] last_stamp_ff, last_stamp_in;
   req_payload_type item_ff, item_in;
   logic [31:0] dt_ff, dt_in;
   logic [31:0] mhi_ff, mhi_in, klo_ff, klo_in;
   logic [31:0] step_ff, step_in, rot_ff, rot_in;
   logic [63:0] py_ff, py_in;
   logic [31:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [65:0] accx_ff, accx_in, accy_ff, accy_in;
   rsp_payload_type res_ff, res_in, rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        div_start, cordic_start;
   logic [63:0] div_quo;
   unit_status_type div_status, cordic_status;
   logic signed [33:0] cos_q30, sin_q30;

   logic        accept;
   logic [38:0] mid;
   logic [31:0] r_full, r_half;
   logic [31:0] c_mag, s_mag, bq_mag;
   logic        c_neg, s_neg, x_neg, y_neg;
   logic [31:0] new_px, new_py;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? 32'(~v + 32'd1) : v;
   endfunction

   function automatic logic signed [65:0] sprod(input logic [63:0] p, input logic neg);
      logic signed [65:0] r;
      r = $signed({2'b00, p});
      return neg ? -r : r;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] p, input logic [35:0] d);
      logic signed [36:0] s;
      s = $signed({{5{p[31]}}, p}) + $signed({d[35], d});
      if (s > 37'sd2147483647) return 32'h7FFF_FFFF;
      if (s < -37'sd2147483648) return 32'h8000_0000;
      return s[31:0];
   endfunction

   opi_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   opi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((state_ff == ST_MUL_VY) ? mul_p : py_ff),
      .quotient (div_quo),
      .status   (div_status)
   );

   opi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (rot_ff),
      .cos_q30 (cos_q30),
      .sin_q30 (sin_q30),
      .status  (cordic_status)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // angle step: floor(m * K / 2^32), keep bits from 6 (full) or 7 (half)
   assign mid    = mul_p[38:0] + {7'd0, klo_ff};
   assign r_full = held_w_ff[31] ? 32'(32'd0 - mid[37:6]) : mid[37:6];
   assign r_half = held_w_ff[31] ? 32'(32'd0 - mid[38:7]) : mid[38:7];

   assign c_neg  = cos_q30[33];
   assign s_neg  = sin_q30[33];
   assign c_mag  = c_neg ? 32'(-cos_q30) : cos_q30[31:0];
   assign s_mag  = s_neg ? 32'(-sin_q30) : sin_q30[31:0];
   assign x_neg  = held_x_ff[31];
   assign y_neg  = held_y_ff[31];
   // displacement magnitude saturates at 2^32 - 1
   assign bq_mag = (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quo[31:0];

   assign new_px = sat_add(pose_x_ff, accx_ff[65:30]);
   assign new_py = sat_add(pose_y_ff, accy_ff[65:30]);

   always_comb begin
      state_in      = state_ff;
      integ_in      = csr_wr_en ? csr_wr_data : integ_ff;
      pose_x_in     = pose_x_ff;
      pose_y_in     = pose_y_ff;
      pose_h_in     = pose_h_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_w_in     = held_w_ff;
      last_stamp_in = last_stamp_ff;
      item_in       = item_ff;
      dt_in         = dt_ff;
      mhi_in        = mhi_ff;
      klo_in        = klo_ff;
      step_in       = step_ff;
      rot_in        = rot_ff;
      py_in         = py_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      accx_in       = accx_ff;
      accy_in       = accy_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mul_a         = mag32(held_w_ff);
      mul_b         = dt_ff;
      div_start     = 1'b0;
      cordic_start  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_payload;
               dt_in   = 32'(req_payload.stamp_us - last_stamp_ff);
               if (req_payload.mode == MODE_RESET) begin
                  res_in.reply_kind  = KIND_RESET;
                  res_in.pos_x       = pose_x_ff;
                  res_in.pos_y       = pose_y_ff;
                  res_in.heading     = pose_h_ff;
                  res_in.twist_x     = '0;
                  res_in.twist_y     = '0;
                  res_in.twist_omega = '0;
                  pose_x_in          = req_payload.new_x;
                  pose_y_in          = req_payload.new_y;
                  pose_h_in          = req_payload.new_heading;
                  state_in           = ST_OUT;
               end else begin
                  state_in = ST_MUL_M;
               end
            end
         end
         ST_MUL_M: begin
            state_in = ST_MUL_KL;
         end
         ST_MUL_KL: begin
            mul_a    = mul_p[31:0];
            mul_b    = ANG_K;
            mhi_in   = mul_p[63:32];
            state_in = ST_MUL_KH;
         end
         ST_MUL_KH: begin
            mul_a    = mhi_ff;
            mul_b    = ANG_K;
            klo_in   = mul_p[63:32];
            state_in = ST_MUL_VX;
         end
         ST_MUL_VX: begin
            step_in  = r_full;
            rot_in   = (integ_ff == INTEG_MIDPOINT) ? 32'(pose_h_ff + r_half) : pose_h_ff;
            mul_a    = mag32(held_x_ff);
            state_in = ST_MUL_VY;
         end
         ST_MUL_VY: begin
            mul_a        = mag32(held_y_ff);
            div_start    = 1'b1;
            cordic_start = 1'b1;
            state_in     = ST_DIV_X;
         end
         ST_DIV_X: begin
            // keep the vy product steady and hold it for the second pass
            mul_a = mag32(held_y_ff);
            py_in = mul_p;
            if (div_status.done) begin
               bx_in     = bq_mag;
               div_start = 1'b1;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_status.done && cordic_status.done) begin
               by_in    = bq_mag;
               state_in = ST_MUL_XC;
            end
         end
         ST_MUL_XC: begin
            mul_a    = bx_ff;
            mul_b    = c_mag;
            state_in = ST_MUL_YS;
         end
         ST_MUL_YS: begin
            accx_in  = sprod(mul_p, x_neg ^ c_neg);
            mul_a    = by_ff;
            mul_b    = s_mag;
            state_in = ST_MUL_XS;
         end
         ST_MUL_XS: begin
            accx_in  = accx_ff - sprod(mul_p, y_neg ^ s_neg);
            mul_a    = bx_ff;
            mul_b    = s_mag;
            state_in = ST_MUL_YC;
         end
         ST_MUL_YC: begin
            accy_in  = sprod(mul_p, x_neg ^ s_neg);
            mul_a    = by_ff;
            mul_b    = c_mag;
            state_in = ST_SUM_Y;
         end
         ST_SUM_Y: begin
            accy_in  = accy_ff + sprod(mul_p, y_neg ^ c_neg);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            pose_x_in          = new_px;
            pose_y_in          = new_py;
            pose_h_in          = 32'(pose_h_ff + step_ff);
            res_in.reply_kind  = KIND_UPDATE;
            res_in.pos_x       = new_px;
            res_in.pos_y       = new_py;
            res_in.heading     = 32'(pose_h_ff + step_ff);
            res_in.twist_x     = held_x_ff;
            res_in.twist_y     = held_y_ff;
            res_in.twist_omega = held_w_ff;
            held_x_in          = item_ff.lin_x;
            held_y_in          = item_ff.lin_y;
            held_w_in          = item_ff.ang_z;
            last_stamp_in      = item_ff.stamp_us;
            state_in           = ST_OUT;
         end
         ST_OUT: begin
            // result register free or draining this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         integ_ff      <= INTEG_EULER;
         rsp_valid_ff  <= 1'b0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         pose_h_ff     <= '0;
         held_x_ff     <= '0;
         held_y_ff     <= '0;
         held_w_ff     <= '0;
         last_stamp_ff <= '0;
      end else begin
         state_ff      <= state_in;
         integ_ff      <= integ_in;
         rsp_valid_ff  <= rsp_valid_in;
         pose_x_ff     <= pose_x_in;
         pose_y_ff     <= pose_y_in;
         pose_h_ff     <= pose_h_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         held_w_ff     <= held_w_in;
         last_stamp_ff <= last_stamp_in;
      end
      item_ff <= item_in;
      dt_ff   <= dt_in;
      mhi_ff  <= mhi_in;
      klo_ff  <= klo_in;
      step_ff <= step_in;
      rot_ff  <= rot_in;
      py_ff   <= py_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // a pose reset goes straight to the result stage
   a_reset_to_out : assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.mode == MODE_RESET |=> state_ff == ST_OUT)
      else $error("pose reset did not reach result stage");

   // products start only once both iterative units have finished
   a_units_done : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL_XC |-> div_status.done && cordic_status.done)
      else $error("rotation started before units finished");

   // divider is never restarted mid-pass
   a_div_no_restart : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import opi_pkg::*;

   localparam int ENTRY_ITEM  = 0;
   localparam int ENTRY_CSR   = 1;
   localparam int ENTRY_DRAIN = 2;
   localparam int IDLE_PCT    = 24;
   localparam int QUIET_GAP   = 8;

   typedef struct {
      int              kind;
      logic            csr_val;
      req_payload_type item;
   } work_entry_type;

   // arctangent of 2^-i, binary angle with a quarter turn at 2^30
   localparam longint ATAN_STEPS [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en = 1'b0;
   logic            csr_wr_data = 1'b0;

   planar_odometry_integrator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // tracked pose and held twist
   logic signed [31:0] trk_x, trk_y, trk_vx, trk_vy, trk_wz;
   logic [31:0]        trk_heading, trk_stamp;
   logic               trk_midpoint;

   work_entry_type  work_list[$];
   rsp_payload_type poses_due[$];
   int  fail_count = 0;
   int  sent_count = 0;
   int  reset_count = 0;
   int  checked_count = 0;
   int  quiet_cycles = 0;
   bit  calm = 0;
   logic [31:0] gen_stamp = 0;

   function automatic logic [63:0] magnitude(input logic signed [31:0] v);
      longint w;
      w = v;
      return (w < 0) ? 64'(-w) : 64'(w);
   endfunction

   // heading advance in binary-angle units, extra shift gives the half step
   function automatic logic [31:0] heading_advance(input logic signed [31:0] w,
                                                   input logic [31:0] dt,
                                                   input int extra);
      logic [63:0] m, lo, hi, mid;
      logic [31:0] r;
      m   = magnitude(w) * {32'd0, dt};
      lo  = {32'd0, m[31:0]} * {32'd0, ANG_K};
      hi  = (m >> 32) * {32'd0, ANG_K};
      mid = hi + (lo >> 32);
      r   = 32'(mid >> (6 + extra));
      return (w < 0) ? -r : r;
   endfunction

   function automatic longint body_travel(input logic signed [31:0] v,
                                          input logic [31:0] dt);
      logic [63:0] d;
      longint s;
      d = (magnitude(v) * {32'd0, dt}) / 64'd1000000;
      s = (d > 64'd4294967295) ? 64'd4294967295 : longint'(d);
      return (v < 0) ? -s : s;
   endfunction

   task automatic cordic_sincos(input logic [31:0] ang, output longint c,
                                output longint s);
      longint z, x, y, nx;
      bit flip;
      z = longint'($signed(ang));
      flip = 0;
      x = 652032874;
      y = 0;
      if (z > 1073741824) begin
         z -= 64'sd2147483648;
         flip = 1;
      end else if (z < -1073741824) begin
         z += 64'sd2147483648;
         flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ATAN_STEPS[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ATAN_STEPS[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [31:0] clamp_add(input logic signed [31:0] p,
                                                    input longint d);
      longint r;
      r = longint'(p) + d;
      if (r > 64'sd2147483647) return 32'sh7fffffff;
      if (r < -64'sd2147483648) return 32'sh80000000;
      return 32'(r);
   endfunction

   // advance the tracked state by one accepted transfer, queue the pose due
   task automatic integrate_pose(input req_payload_type it);
      rsp_payload_type r;
      logic [31:0] dt, rot;
      longint bx, by, c, s, dx, dy;
      r = '0;
      if (it.mode == MODE_RESET) begin
         r.reply_kind = KIND_RESET;
         r.pos_x = trk_x;
         r.pos_y = trk_y;
         r.heading = trk_heading;
         trk_x = it.new_x;
         trk_y = it.new_y;
         trk_heading = it.new_heading;
         reset_count++;
      end else begin
         dt  = it.stamp_us - trk_stamp;
         rot = trk_heading;
         if (trk_midpoint == INTEG_MIDPOINT) rot += heading_advance(trk_wz, dt, 1);
         bx = body_travel(trk_vx, dt);
         by = body_travel(trk_vy, dt);
         cordic_sincos(rot, c, s);
         dx = (bx * c - by * s) >>> 30;
         dy = (bx * s + by * c) >>> 30;
         trk_x = clamp_add(trk_x, dx);
         trk_y = clamp_add(trk_y, dy);
         trk_heading += heading_advance(trk_wz, dt, 0);
         r.reply_kind = KIND_UPDATE;
         r.pos_x = trk_x;
         r.pos_y = trk_y;
         r.heading = trk_heading;
         r.twist_x = trk_vx;
         r.twist_y = trk_vy;
         r.twist_omega = trk_wz;
         trk_vx = it.lin_x;
         trk_vy = it.lin_y;
         trk_wz = it.ang_z;
         trk_stamp = it.stamp_us;
      end
      poses_due.push_back(r);
   endtask

   function automatic logic [31:0] pick_speed();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
      endcase
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type it;
      int roll;
      it.mode = MODE_VELOCITY;
      it.stamp_us = 0;
      it.lin_x = pick_speed();
      it.lin_y = pick_speed();
      it.ang_z = pick_speed();
      it.new_x = $urandom();
      it.new_y = $urandom();
      it.new_heading = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         it.mode = MODE_RESET;
         if ($urandom_range(0, 1)) begin
            it.new_x = 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
            it.new_y = 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
         end
      end else if (roll < 11) begin
         // noise: any stamp, any speeds
         it.stamp_us = $urandom();
         it.lin_x = $urandom();
         it.ang_z = $urandom();
      end else if (roll < 14) begin
         // stamp runs backwards
         it.stamp_us = gen_stamp - 32'($urandom_range(1, 5000));
      end else begin
         it.stamp_us = gen_stamp + 32'($urandom_range(1, 200000));
      end
      if (it.mode == MODE_VELOCITY) gen_stamp = it.stamp_us;
      return it;
   endfunction

   function automatic req_payload_type velocity_item(input logic [31:0] st,
                                                     input logic [31:0] vx,
                                                     input logic [31:0] vy,
                                                     input logic [31:0] wz);
      req_payload_type it;
      it = '0;
      it.mode = MODE_VELOCITY;
      it.stamp_us = st;
      it.lin_x = vx;
      it.lin_y = vy;
      it.ang_z = wz;
      gen_stamp = st;
      return it;
   endfunction

   function automatic req_payload_type reset_item(input logic [31:0] nx,
                                                  input logic [31:0] ny,
                                                  input logic [31:0] nh);
      req_payload_type it;
      it = '0;
      it.mode = MODE_RESET;
      it.new_x = nx;
      it.new_y = ny;
      it.new_heading = nh;
      return it;
   endfunction

   task automatic queue_item(input req_payload_type it);
      work_entry_type e;
      e.kind = ENTRY_ITEM;
      e.csr_val = 1'b0;
      e.item = it;
      work_list.push_back(e);
   endtask

   task automatic queue_hold(input int kind, input logic val);
      work_entry_type e;
      e.kind = kind;
      e.csr_val = val;
      e.item = '0;
      work_list.push_back(e);
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch on %s: got %h, want %h", field, got, want);
      fail_count++;
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   // driver: presents pending transfers, applies mode writes while idle
   always @(posedge clock) begin : drive
      bit take, nv, nwe;
      req_payload_type np;
      take = req_valid && !req_stall;
      nv   = req_valid && !take;
      np   = req_payload;
      nwe  = 1'b0;
      if (!reset) begin
         if (take) begin
            integrate_pose(req_payload);
            sent_count++;
         end
         calm = (sent_count >= 150 && sent_count < 260);
         if (poses_due.size() == 0 && !nv) quiet_cycles++;
         else quiet_cycles = 0;
         if (!nv && work_list.size() > 0) begin
            case (work_list[0].kind)
               ENTRY_ITEM: begin
                  if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
                     np = work_list[0].item;
                     nv = 1'b1;
                     void'(work_list.pop_front());
                  end
               end
               default: begin
                  // wait for the block to drain before touching the mode
                  if (quiet_cycles >= QUIET_GAP) begin
                     if (work_list[0].kind == ENTRY_CSR) begin
                        nwe = 1'b1;
                        csr_wr_data <= work_list[0].csr_val;
                        trk_midpoint = work_list[0].csr_val;
                     end
                     quiet_cycles = 0;
                     void'(work_list.pop_front());
                  end
               end
            endcase
         end
      end
      req_valid   <= nv;
      req_payload <= np;
      csr_wr_en   <= nwe;
   end

   // monitor: checks each result transfer against the oldest pose due
   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (poses_due.size() == 0) begin
            $display("result transfer with nothing due");
            fail_count++;
         end else begin
            want = poses_due.pop_front();
            checked_count++;
            if (rsp_payload.reply_kind !== want.reply_kind)
               note_mismatch("reply_kind", 32'(rsp_payload.reply_kind),
                             32'(want.reply_kind));
            if (rsp_payload.pos_x !== want.pos_x)
               note_mismatch("pos_x", rsp_payload.pos_x, want.pos_x);
            if (rsp_payload.pos_y !== want.pos_y)
               note_mismatch("pos_y", rsp_payload.pos_y, want.pos_y);
            if (rsp_payload.heading !== want.heading)
               note_mismatch("heading", rsp_payload.heading, want.heading);
            if (rsp_payload.twist_x !== want.twist_x)
               note_mismatch("twist_x", rsp_payload.twist_x, want.twist_x);
            if (rsp_payload.twist_y !== want.twist_y)
               note_mismatch("twist_y", rsp_payload.twist_y, want.twist_y);
            if (rsp_payload.twist_omega !== want.twist_omega)
               note_mismatch("twist_omega", rsp_payload.twist_omega,
                             want.twist_omega);
         end
      end
      rsp_stall <= (!reset && !calm && $urandom_range(0, 99) < IDLE_PCT);
   end

   initial begin
      #20000000;
      $display("timeout");
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      trk_x = 0; trk_y = 0; trk_heading = 0;
      trk_vx = 0; trk_vy = 0; trk_wz = 0;
      trk_stamp = 0; trk_midpoint = INTEG_EULER;

      // directed: first sample after reset leaves the pose alone
      queue_item(velocity_item(32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
      queue_item(velocity_item(32'h00000010, 32'h00010000, 32'h00000000, 32'h00010000));
      queue_item(velocity_item(32'h000f4250, 32'h80000000, 32'h7fffffff, 32'h80000000));
      // long step at full speed drives the position into saturation
      queue_item(velocity_item(32'h7ff00000, 32'h7fffffff, 32'h7fffffff, 32'h00000000));
      queue_item(velocity_item(32'hfff00000, 32'h00020000, 32'hfffe0000, 32'h00008000));
      queue_item(reset_item(32'h80000000, 32'h7fffffff, 32'hffffffff));
      queue_item(reset_item(32'h00000000, 32'h00000000, 32'h80000000));
      // stamp going backwards wraps dt
      queue_item(velocity_item(32'h00001000, 32'h00010000, 32'h00010000, 32'hffff0000));
      queue_item(reset_item(32'hffff0000, 32'h00010000, 32'h40000000));
      queue_item(velocity_item(32'h00002000, 32'h00000000, 32'h00000000, 32'h00000000));
      queue_item(reset_item(32'h00000000, 32'h00000000, 32'hc0000000));
      queue_item(velocity_item(32'h00003000, 32'hffffffff, 32'h00000001, 32'h7fffffff));
      queue_item(velocity_item(32'h00004000, 32'h00000000, 32'h00000000, 32'h00000000));
      for (int i = 0; i < 220; i++) begin
         queue_item(random_item());
         if (i == 110) queue_hold(ENTRY_DRAIN, 1'b0);
      end

      // midpoint phase
      queue_hold(ENTRY_CSR, INTEG_MIDPOINT);
      queue_item(reset_item(32'h00000000, 32'h00000000, 32'h3fffffff));
      queue_item(velocity_item(gen_stamp + 32'd1000, 32'h00010000, 32'h00000000,
                               32'h7fffffff));
      queue_item(velocity_item(gen_stamp + 32'd50000, 32'h80000000, 32'h7fffffff,
                               32'h80000000));
      queue_item(velocity_item(gen_stamp + 32'd90000000, 32'h00000000, 32'h00000000,
                               32'h00000000));
      for (int i = 0; i < 220; i++) queue_item(random_item());

      // back to euler, then midpoint again
      queue_hold(ENTRY_CSR, INTEG_EULER);
      for (int i = 0; i < 40; i++) queue_item(random_item());
      queue_hold(ENTRY_CSR, INTEG_MIDPOINT);
      for (int i = 0; i < 20; i++) queue_item(random_item());

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (work_list.size() > 0 || req_valid || poses_due.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      $display("%0d transfers in (%0d pose resets), %0d results checked",
               sent_count, reset_count, checked_count);
      $display("euler and midpoint modes, saturation, wrapped stamps, stalls on both sides");
      if (fail_count == 0 && poses_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d failures", fail_count + poses_due.size());
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

FILE: sim.f
src/opi_pkg.sv
src/opi_mul.sv
src/opi_div.sv
src/opi_cordic.sv
src/planar_odometry_integrator_core.sv
tb/sv/tb.sv
